/* design/rpc_pkg.sv */
// Shared types, codes and helpers for the relocation patch calculator.
// No dependencies; used by every module in the design folder.
package rpc_pkg;

  localparam int ADDR_WIDTH = 64;
  localparam logic [63:0] ADDR_MASK =
    (ADDR_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << ADDR_WIDTH) - 64'd1);

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CACHE_BASE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIG_LOAD_BASE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CACHE_OFFSET   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHADOW_OFFSET  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENT_BASE   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHADOW_MODE    = 3'd5;

  localparam logic [1:0] MODE_SEGMENT    = 2'd1;
  localparam logic [1:0] MODE_SEGMENT_PP = 2'd2;

  localparam logic [3:0] SEL_RIP      = 4'd0;
  localparam logic [3:0] SEL_BRANCH   = 4'd1;
  localparam logic [3:0] SEL_SHADOW   = 4'd2;
  localparam logic [3:0] SEL_CACHE_IM = 4'd3;
  localparam logic [3:0] SEL_CACHE_HI = 4'd4;
  localparam logic [3:0] SEL_CACHE_LO = 4'd5;
  localparam logic [3:0] SEL_ORIG_HI  = 4'd6;
  localparam logic [3:0] SEL_ORIG_LO  = 4'd7;
  localparam logic [3:0] SEL_TRAMP    = 4'd8;
  localparam logic [3:0] SEL_DBG_HI   = 4'd9;
  localparam logic [3:0] SEL_DBG_LO   = 4'd10;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PAST_END = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE = 3'd2;
  localparam logic [2:0] ST_NO_TRAMP = 3'd3;
  localparam logic [2:0] ST_NO_SEG   = 3'd4;

  localparam logic [7:0] PATCH_BYTES = 8'd4;

  typedef struct packed {
    logic [63:0] cache_base;
    logic [63:0] orig_load_base;
    logic [63:0] cache_offset;
    logic [63:0] shadow_offset;
    logic [63:0] segment_base;
    logic [1:0]  shadow_mode;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  reloc_kind;
    logic        debug_low;
    logic [15:0] patch_pos;
    logic [7:0]  patch_size;
    logic [31:0] addend;
    logic [63:0] reloc_value;
    logic [63:0] block_addr;
    logic [15:0] block_len;
    logic [31:0] origin_offset;
    logic        has_fallthrough;
    logic [63:0] dest_addr;
    logic [63:0] trampoline_offset;
  } item_t;

  typedef struct packed {
    logic [3:0]  sel;
    logic [2:0]  status;
    logic [63:0] patch_addr;
    logic [63:0] cc_load;
    logic [63:0] gen_rel;
    logic [63:0] tgt_rel;
    logic [63:0] vo_sum;
    logic [31:0] addend;
    logic [31:0] value_lo;
    logic [31:0] cur_bbl_lo;
    logic [31:0] tramp_lo;
    logic [31:0] virt_ss_lo;
    logic [31:0] cache_off_lo;
  } s1_t;

  typedef struct packed {
    logic [3:0]  sel;
    logic [2:0]  status;
    logic [63:0] patch_addr;
    logic [63:0] cur_rbbl;
    logic [63:0] tgt_reloc;
    logic [31:0] rip_part;
    logic [31:0] addend;
    logic [31:0] simple_word;
  } s2_t;

  typedef struct packed {
    logic [63:0] patch_addr;
    logic [31:0] patch_word;
    logic [2:0]  status;
  } res_t;

  function automatic logic [63:0] amask(input logic [63:0] v);
    return v & ADDR_MASK;
  endfunction

  function automatic logic [31:0] hi_half(input logic [63:0] v);
    logic [63:0] m;
    m = v & ADDR_MASK;
    return m[63:32];
  endfunction

endpackage

/* design/rpc_prep.sv */
// First pipeline stage: kind decode, status checks and the independent sums.
// Depends on rpc_pkg.
module rpc_prep (
  input  logic           clk,
  input  logic           rst,
  input  rpc_pkg::cfg_t  cfg,
  input  logic           up_valid,
  output logic           up_ready,
  input  rpc_pkg::item_t item,
  output logic           dn_valid,
  input  logic           dn_ready,
  output rpc_pkg::s1_t   dn_data
);

  logic         advance;
  logic         seg_mode;
  logic         sized;
  logic [3:0]   sel;
  logic [2:0]   status_next;
  logic [63:0]  tgt_src;
  logic [63:0]  virt_ss;
  rpc_pkg::s1_t data_next;

  assign advance  = !dn_valid || dn_ready;
  assign up_ready = advance;

  always_comb begin
    seg_mode = (cfg.shadow_mode == rpc_pkg::MODE_SEGMENT) ||
               (cfg.shadow_mode == rpc_pkg::MODE_SEGMENT_PP);
    sel   = item.debug_low ? rpc_pkg::SEL_DBG_LO : item.reloc_kind;
    sized = (sel <= rpc_pkg::SEL_CACHE_IM) || (sel == rpc_pkg::SEL_TRAMP);
    if (item.patch_pos >= item.block_len) begin
      status_next = rpc_pkg::ST_PAST_END;
    end else if (seg_mode && (cfg.segment_base == 64'd0)) begin
      status_next = rpc_pkg::ST_NO_SEG;
    end else if (sized && (item.patch_size != rpc_pkg::PATCH_BYTES)) begin
      status_next = rpc_pkg::ST_BAD_SIZE;
    end else if ((sel == rpc_pkg::SEL_TRAMP) && (item.trampoline_offset == 64'd0)) begin
      status_next = rpc_pkg::ST_NO_TRAMP;
    end else begin
      status_next = rpc_pkg::ST_OK;
    end
    tgt_src = item.has_fallthrough ? item.dest_addr : cfg.cache_base;
    // Branch uses the target even without fallthrough
    if (sel == rpc_pkg::SEL_BRANCH) tgt_src = item.dest_addr;
    virt_ss = seg_mode ? cfg.shadow_offset + cfg.segment_base : cfg.shadow_offset;

    data_next.sel          = sel;
    data_next.status       = status_next;
    data_next.patch_addr   = rpc_pkg::amask(item.block_addr + {48'd0, item.patch_pos});
    data_next.cc_load      = rpc_pkg::amask(cfg.orig_load_base + cfg.cache_offset);
    data_next.gen_rel      = item.block_addr - cfg.cache_base;
    data_next.tgt_rel      = tgt_src - cfg.cache_base;
    data_next.vo_sum       = item.reloc_value + cfg.orig_load_base;
    data_next.addend       = item.addend;
    data_next.value_lo     = item.reloc_value[31:0];
    data_next.cur_bbl_lo   = cfg.orig_load_base[31:0] + item.origin_offset;
    data_next.tramp_lo     = item.trampoline_offset[31:0];
    data_next.virt_ss_lo   = virt_ss[31:0];
    data_next.cache_off_lo = cfg.cache_offset[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (advance) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

/* design/rpc_combine.sv */
// Second pipeline stage: relocated block and target addresses, simple kinds.
// Depends on rpc_pkg.
module rpc_combine (
  input  logic         clk,
  input  logic         rst,
  input  logic         up_valid,
  output logic         up_ready,
  input  rpc_pkg::s1_t up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output rpc_pkg::s2_t dn_data
);

  logic         advance;
  logic [31:0]  simple;
  rpc_pkg::s2_t data_next;

  assign advance  = !dn_valid || dn_ready;
  assign up_ready = advance;

  always_comb begin
    case (up_data.sel)
      rpc_pkg::SEL_SHADOW:   simple = up_data.addend - up_data.virt_ss_lo;
      rpc_pkg::SEL_CACHE_IM: simple = up_data.cache_off_lo + up_data.addend;
      rpc_pkg::SEL_ORIG_HI:  simple = rpc_pkg::hi_half(up_data.vo_sum);
      rpc_pkg::SEL_ORIG_LO:  simple = up_data.vo_sum[31:0];
      rpc_pkg::SEL_TRAMP:    simple = up_data.tramp_lo + up_data.addend;
      default:               simple = 32'd0;
    endcase
    data_next.sel         = up_data.sel;
    data_next.status      = up_data.status;
    data_next.patch_addr  = up_data.patch_addr;
    data_next.cur_rbbl    = rpc_pkg::amask(up_data.gen_rel + up_data.cc_load);
    data_next.tgt_reloc   = rpc_pkg::amask(up_data.tgt_rel + up_data.cc_load);
    data_next.rip_part    = up_data.value_lo + up_data.cur_bbl_lo + up_data.addend;
    data_next.addend      = up_data.addend;
    data_next.simple_word = simple;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (advance) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

/* design/rpc_finish.sv */
// Third pipeline stage and output register: final word select and status gate.
// Depends on rpc_pkg.
module rpc_finish (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  rpc_pkg::s2_t  up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output rpc_pkg::res_t dn_data
);

  logic          advance;
  logic [31:0]   word;
  rpc_pkg::res_t data_next;

  assign advance  = !dn_valid || dn_ready;
  assign up_ready = advance;

  always_comb begin
    case (up_data.sel)
      rpc_pkg::SEL_RIP:      word = up_data.rip_part - up_data.cur_rbbl[31:0];
      rpc_pkg::SEL_BRANCH:   word = up_data.tgt_reloc[31:0] - up_data.cur_rbbl[31:0]
                                    + up_data.addend;
      rpc_pkg::SEL_SHADOW,
      rpc_pkg::SEL_CACHE_IM,
      rpc_pkg::SEL_ORIG_HI,
      rpc_pkg::SEL_ORIG_LO,
      rpc_pkg::SEL_TRAMP:    word = up_data.simple_word;
      rpc_pkg::SEL_CACHE_HI: word = rpc_pkg::hi_half(up_data.tgt_reloc);
      rpc_pkg::SEL_CACHE_LO: word = up_data.tgt_reloc[31:0];
      rpc_pkg::SEL_DBG_HI:   word = rpc_pkg::hi_half(up_data.cur_rbbl);
      rpc_pkg::SEL_DBG_LO:   word = up_data.cur_rbbl[31:0];
      default:               word = 32'd0;
    endcase
    data_next.patch_addr = up_data.patch_addr;
    data_next.patch_word = (up_data.status == rpc_pkg::ST_OK) ? word : 32'd0;
    data_next.status     = up_data.status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (advance) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      dn_data <= data_next;
    end
  end

endmodule

/* design/relocation_patch_calculator_top.sv */
// Relocation patch calculator: one relocation entry in, one patch address,
// patch word and status out. Three register stages (prep, combine, finish);
// one item per cycle sustained while the output drains.
// Each stage holds while the next is full and stalled, so in_ready falls only
// once all three stages hold items. Configuration is written through a plain
// write port and must only change while no item is in flight.
// Depends on rpc_pkg, rpc_prep, rpc_combine and rpc_finish.
module relocation_patch_calculator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [rpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [3:0]                      reloc_kind,
  input  logic                            debug_low,
  input  logic [15:0]                     patch_pos,
  input  logic [7:0]                      patch_size,
  input  logic signed [31:0]              addend,
  input  logic [63:0]                     reloc_value,
  input  logic [63:0]                     block_addr,
  input  logic [15:0]                     block_len,
  input  logic [31:0]                     origin_offset,
  input  logic                            has_fallthrough,
  input  logic [63:0]                     dest_addr,
  input  logic [63:0]                     trampoline_offset,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [63:0]                     patch_addr,
  output logic signed [31:0]              patch_word,
  output logic [2:0]                      status
);

  rpc_pkg::cfg_t  cfg;
  rpc_pkg::item_t item;
  rpc_pkg::s1_t   s1_data;
  rpc_pkg::s2_t   s2_data;
  rpc_pkg::res_t  res;
  logic           s1_valid;
  logic           s1_ready;
  logic           s2_valid;
  logic           s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rpc_pkg::CFG_CACHE_BASE:     cfg.cache_base     <= cfg_data;
        rpc_pkg::CFG_ORIG_LOAD_BASE: cfg.orig_load_base <= cfg_data;
        rpc_pkg::CFG_CACHE_OFFSET:   cfg.cache_offset   <= cfg_data;
        rpc_pkg::CFG_SHADOW_OFFSET:  cfg.shadow_offset  <= cfg_data;
        rpc_pkg::CFG_SEGMENT_BASE:   cfg.segment_base   <= cfg_data;
        rpc_pkg::CFG_SHADOW_MODE:    cfg.shadow_mode    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    item.reloc_kind        = reloc_kind;
    item.debug_low         = debug_low;
    item.patch_pos         = patch_pos;
    item.patch_size        = patch_size;
    item.addend            = addend;
    item.reloc_value       = reloc_value;
    item.block_addr        = block_addr;
    item.block_len         = block_len;
    item.origin_offset     = origin_offset;
    item.has_fallthrough   = has_fallthrough;
    item.dest_addr         = dest_addr;
    item.trampoline_offset = trampoline_offset;
  end

  rpc_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .item     (item),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  rpc_combine u_combine (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  rpc_finish u_finish (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (res)
  );

  assign patch_addr = res.patch_addr;
  assign patch_word = res.patch_word;
  assign status     = res.status;

  a_word_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != rpc_pkg::ST_OK) |-> patch_word == 32'sd0)
    else $error("nonzero patch word with error status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= rpc_pkg::ST_NO_SEG)
    else $error("status code out of range");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready && s1_valid && s2_valid)
    else $error("input stalled with room in the pipeline");

  a_drain_moves: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !out_valid |=> out_valid)
    else $error("item lost between last stages");

endmodule
